// ===== hdl/cnmf_pkg.sv =====
package cnmf_pkg;

    // configuration register file
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    localparam logic [CFG_W-1:0] IMAGE_WIDTH_RESET  = 11'd1024;
    localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RESET = 11'd1024;

    // stream payload
    localparam int PIX_FIELD_W = 4;
    localparam int TDATA_W     = 8;

endpackage

// ===== hdl/cnmf_ram.sv =====
module cnmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hdl/cross_neighbour_min_filter.sv =====
// Four-neighbour min filter (grayscale erosion with a cross element, center
// excluded) over a raster streamed in row order, one pixel per item. An item
// with tuser = 0 carries a pixel; an interior pixel's result is the minimum of
// its up, down, left and right neighbors, border pixels give zero. Results lag
// by one row: the pixel at row r >= 1 releases the result for row r-1, same
// column; row 0 pixels produce nothing. Once the last pixel of the image is in,
// send one drain item (tuser = 1) per column to get the final row (all zero).
// tlast marks the last result of each row, tuser on the output the last of the
// image. Drain items sent while not draining and pixels sent while draining
// are dropped. Throughput is one item per clock while the output is not stalled:
// both line buffers share one simple dual-port RAM entry per column, written
// once and read once per pixel item, with the next column's entry prefetched
// one item ahead. Each result is registered on the output as its item is taken.
// Write image_width / image_height only between images or while idle.
module cross_neighbour_min_filter #(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // pixel stream in
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [cnmf_pkg::TDATA_W-1:0]        s_axis_tdata,  // [3:0] pixel
    input  logic                                s_axis_tuser,  // [0] mode
    // result stream out
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [cnmf_pkg::TDATA_W-1:0]        m_axis_tdata,  // [3:0] value
    output logic                                m_axis_tlast,  // row_end
    output logic                                m_axis_tuser,  // [0] image_end
    // configuration
    input  logic                                cfg_we,
    input  logic [cnmf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cnmf_pkg::CFG_W-1:0]          cfg_data
);

    import cnmf_pkg::*;

    // stored pixel bits: the field is PIX_FIELD_W wide
    localparam int SB    = (PIXEL_BITS < PIX_FIELD_W) ? PIXEL_BITS : PIX_FIELD_W;
    localparam int ENT_W = 2 * SB;                 // {two_rows_back, previous_row}
    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int WB    = $clog2(MAX_WIDTH + 1);
    localparam int KW    = ((CFG_W > WB) ? CFG_W : WB) + 1;

    typedef struct packed {
        logic [SB-1:0] two;
        logic [SB-1:0] prev;
    } entry_t;

    // control state
    logic [CFG_W-1:0] width_reg, width_next;
    logic [CFG_W-1:0] height_reg, height_next;
    logic [AW-1:0]    col_reg, col_next;      // pixel column, or drain column
    logic [CFG_W-1:0] row_reg, row_next;
    logic             drain_reg, drain_next;
    logic             fwd_reg, fwd_next;
    logic             ovalid_reg, ovalid_next;

    // payload
    entry_t           cur_reg, cur_next;      // entry of the upcoming column
    entry_t           first_reg, first_next;  // column 0 entry of this row
    logic [SB-1:0]    left_reg, left_next;    // row r-1, column c-1
    entry_t           fwd_data_reg, fwd_data_next;
    logic [SB-1:0]    oval_reg, oval_next;
    logic             olast_reg, olast_next;
    logic             oend_reg, oend_next;

    // RAM port
    logic             ram_we, ram_re;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    entry_t           ram_wdata, ram_rdata;

    // decode
    logic             accept, is_drain;
    logic [SB-1:0]    px;
    logic [KW-1:0]    weff, col_p1, raddr_k;
    logic [CFG_W-1:0] heff;
    logic             last_col, last_row, interior;
    entry_t           right;
    logic [SB-1:0]    m1, m2, vmin;

    cnmf_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_axis_tready = !ovalid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign is_drain      = s_axis_tuser;
    assign px            = s_axis_tdata[SB-1:0];

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = TDATA_W'(oval_reg);
    assign m_axis_tlast  = olast_reg;
    assign m_axis_tuser  = oend_reg;

    always_comb
    begin
        // effective geometry: zero acts as one, width saturates at MAX_WIDTH
        if (width_reg == '0)
        begin
            weff = KW'(1);
        end
        else if (KW'(width_reg) > KW'(MAX_WIDTH))
        begin
            weff = KW'(MAX_WIDTH);
        end
        else
        begin
            weff = KW'(width_reg);
        end
        heff = (height_reg == '0) ? CFG_W'(1) : height_reg;

        col_p1   = KW'(col_reg) + KW'(1);
        last_col = (col_p1 >= weff);
        last_row = ((KW'(row_reg) + KW'(1)) >= KW'(heff));
        interior = (row_reg >= CFG_W'(2)) && (col_reg != '0) && !last_col;

        // prefetched entry of column c+1, bypassed if written on the read edge
        right = fwd_reg ? fwd_data_reg : ram_rdata;

        m1   = (cur_reg.two < left_reg) ? cur_reg.two : left_reg;
        m2   = (right.prev < px) ? right.prev : px;
        vmin = (m1 < m2) ? m1 : m2;

        // line buffer: row r-1 moves to r-2, the new pixel becomes row r-1
        ram_wdata.two  = cur_reg.prev;
        ram_wdata.prev = px;
        ram_waddr      = col_reg;
        raddr_k        = last_col ? KW'(1) : (KW'(col_reg) + KW'(2));
        ram_raddr      = (raddr_k >= KW'(MAX_WIDTH)) ? '0 : AW'(raddr_k);

        width_next    = width_reg;
        height_next   = height_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        drain_next    = drain_reg;
        fwd_next      = fwd_reg;
        ovalid_next   = ovalid_reg && !m_axis_tready;
        cur_next      = cur_reg;
        first_next    = first_reg;
        left_next     = left_reg;
        fwd_data_next = fwd_data_reg;
        oval_next     = oval_reg;
        olast_next    = olast_reg;
        oend_next     = oend_reg;
        ram_we        = 1'b0;
        ram_re        = 1'b0;

        if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_IMAGE_WIDTH:  width_next  = cfg_data;
                REG_IMAGE_HEIGHT: height_next = cfg_data;
                default:          ;
            endcase
        end

        if (accept && is_drain && drain_reg)
        begin
            // final row: all border
            ovalid_next = 1'b1;
            oval_next   = '0;
            olast_next  = last_col;
            oend_next   = last_col;
            if (last_col)
            begin
                drain_next = 1'b0;
                col_next   = '0;
                row_next   = '0;
            end
            else
            begin
                col_next = AW'(col_p1);
            end
        end
        else if (accept && !is_drain && !drain_reg)
        begin
            ram_we = 1'b1;
            ram_re = 1'b1;
            fwd_next      = (ram_raddr == ram_waddr);
            fwd_data_next = ram_wdata;
            left_next     = cur_reg.prev;
            if (col_reg == '0)
            begin
                first_next = ram_wdata;
            end

            if (row_reg != '0)
            begin
                ovalid_next = 1'b1;
                oval_next   = interior ? vmin : '0;
                olast_next  = last_col;
                oend_next   = 1'b0;
            end

            if (last_col)
            begin
                col_next = '0;
                cur_next = (col_reg == '0) ? ram_wdata : first_reg;
                if (last_row)
                begin
                    row_next   = '0;
                    drain_next = 1'b1;
                end
                else
                begin
                    row_next = row_reg + CFG_W'(1);
                end
            end
            else
            begin
                col_next = AW'(col_p1);
                cur_next = right;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= IMAGE_WIDTH_RESET;
            height_reg <= IMAGE_HEIGHT_RESET;
            col_reg    <= '0;
            row_reg    <= '0;
            drain_reg  <= 1'b0;
            fwd_reg    <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            drain_reg  <= drain_next;
            fwd_reg    <= fwd_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        first_reg    <= first_next;
        left_reg     <= left_next;
        fwd_data_reg <= fwd_data_next;
        oval_reg     <= oval_next;
        olast_reg    <= olast_next;
        oend_reg     <= oend_next;
    end

endmodule

// ===== test/cross_neighbour_min_filter_tb.sv =====
module cross_neighbour_min_filter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cnmf_pkg::*;

    localparam int MAX_WIDTH    = 1024;
    localparam int PIXEL_BITS   = 4;
    localparam int LB_AW        = $clog2(MAX_WIDTH);

    // tuser on the input side: what the item carries
    localparam bit MODE_PIXEL   = 1'b0;
    localparam bit MODE_DRAIN   = 1'b1;

    localparam int MAX_GAP      = 13;     // per-item wait, both sides
    localparam int SETTLE_CYCLES = 4;     // margin after the last expected result
    localparam int TAIL_CYCLES  = 8;
    localparam int IDLE_LIMIT   = 2000;   // cycles with no handshake or register write
    localparam int RANDOM_ITEMS = 1500;
    localparam int MAX_REPORTS  = 100;

    // one output item: min of the cross, plus row / image end marks
    typedef struct packed {
        logic [PIXEL_BITS-1:0] value;
        logic                  row_end;
        logic                  image_end;
    } erosion_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [TDATA_W-1:0]     s_axis_tdata;   // [3:0] pixel
    logic                   s_axis_tuser;   // [0] mode
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [TDATA_W-1:0]     m_axis_tdata;   // [3:0] value
    logic                   m_axis_tlast;   // row_end
    logic                   m_axis_tuser;   // [0] image_end
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_W-1:0]       cfg_data;

    cross_neighbour_min_filter #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Erosion predictor: own copy of the line buffers, position counters
    // and size registers. Updated at the edge where an item is accepted.
    // ------------------------------------------------------------------
    logic [CFG_W-1:0]       width_reg  = IMAGE_WIDTH_RESET;
    logic [CFG_W-1:0]       height_reg = IMAGE_HEIGHT_RESET;
    logic [PIXEL_BITS-1:0]  last_line  [MAX_WIDTH];   // row r-1
    logic [PIXEL_BITS-1:0]  older_line [MAX_WIDTH];   // row r-2
    int unsigned            row_pos    = 0;
    int unsigned            col_pos    = 0;
    int unsigned            drain_pos  = 0;
    bit                     draining   = 1'b0;

    erosion_t               erosions_due[$];          // oldest first

    int unsigned            error_count  = 0;
    int unsigned            result_count = 0;
    int unsigned            stream_items = 0;         // well-formed items only
    int unsigned            idle_cycles  = 0;
    int unsigned            stall_left   = 0;         // receiver stall, in cycles
    bit                     burst        = 1'b0;      // no idling on either side

    // 0 reads as 1, anything above the line buffer depth is clamped
    function automatic int unsigned active_width();
        if (width_reg == 0)
            return 1;
        if (width_reg > MAX_WIDTH)
            return MAX_WIDTH;
        return 32'(width_reg);
    endfunction

    function automatic int unsigned active_height();
        return (height_reg == 0) ? 1 : 32'(height_reg);
    endfunction

    function automatic int unsigned draw_gap();
        return burst ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    function automatic void predict_erosion(input bit mode, input logic [PIXEL_BITS-1:0] px);
        int unsigned            w;
        int unsigned            h;
        int unsigned            r;
        int unsigned            c;
        logic [LB_AW-1:0]       ci;
        logic [LB_AW-1:0]       cl;
        logic [LB_AW-1:0]       cr;
        logic [PIXEL_BITS-1:0]  v;
        erosion_t               res;
        w = active_width();
        h = active_height();

        if (mode == MODE_DRAIN)
        begin
            // drain tick only counts once the last pixel is in
            if (!draining)
                return;
            res.value     = '0;               // final row is all border
            res.row_end   = (drain_pos + 1 >= w);
            res.image_end = res.row_end;
            erosions_due.push_back(res);
            if (res.row_end)
            begin
                draining  = 1'b0;
                drain_pos = 0;
                row_pos   = 0;
                col_pos   = 0;
            end
            else
                drain_pos = (drain_pos + 1) & 32'h7FF;
            return;
        end

        // pixels are dropped while the last row drains
        if (draining)
            return;

        r = row_pos;
        c = col_pos;
        if (c >= MAX_WIDTH)
            c = MAX_WIDTH - 1;
        ci = LB_AW'(c);

        // pixel (r, c) completes the cross of (r-1, c)
        if (r >= 1)
        begin
            v = '0;
            if (r >= 2 && c >= 1 && c + 1 < w)
            begin
                cl = LB_AW'(c - 1);
                cr = LB_AW'(c + 1);
                v = older_line[ci];                         // up
                if (older_line[cl] < v) v = older_line[cl]; // left, already shifted
                if (last_line[cr] < v)  v = last_line[cr];  // right
                if (px < v)             v = px;             // down
            end
            res.value     = v;
            res.row_end   = (c + 1 >= w);
            res.image_end = 1'b0;
            erosions_due.push_back(res);
        end

        older_line[ci] = last_line[ci];
        last_line[ci]  = px;

        if (c + 1 >= w)
        begin
            col_pos = 0;
            if (r + 1 >= h)
            begin
                row_pos   = 0;
                draining  = 1'b1;
                drain_pos = 0;
            end
            else
                row_pos = (r + 1) & 32'h7FF;
        end
        else
            col_pos = c + 1;
    endfunction

    // ------------------------------------------------------------------
    // Reporting and result checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        if (error_count < MAX_REPORTS)
            $display("mismatch at %0t ns, result %0d: %s", $time, result_count, msg);
        error_count++;
    endtask

    // outputs sampled at the rising edge; a fresh stall is drawn per item
    always @(posedge clk)
    begin : check_results
        erosion_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (erosions_due.size() == 0)
                report_mismatch("result with nothing expected");
            else
            begin
                want = erosions_due.pop_front();
                if (m_axis_tdata[PIXEL_BITS-1:0] !== want.value)
                    report_mismatch($sformatf("value expected %0d, got %0d",
                                              want.value, m_axis_tdata[PIXEL_BITS-1:0]));
                if (m_axis_tlast !== want.row_end)
                    report_mismatch($sformatf("row_end expected %0b, got %0b",
                                              want.row_end, m_axis_tlast));
                if (m_axis_tuser !== want.image_end)
                    report_mismatch($sformatf("image_end expected %0b, got %0b",
                                              want.image_end, m_axis_tuser));
            end
            result_count++;
            stall_left = draw_gap();
        end
    end

    // receiver: holds tready low for the drawn number of cycles
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // watchdog: any handshake or register write counts as progress
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
            idle_cycles = 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
            $display("tb: failure");
            $finish;
        end
        else
            idle_cycles = idle_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers. All of them start and end at a falling edge.
    // ------------------------------------------------------------------

    // One input item: optional gap, then hold tvalid until accepted.
    // tvalid is only lowered when a gap is drawn, so back-to-back items
    // never see two assignments to it in one step.
    task automatic send_item(input bit mode, input logic [PIXEL_BITS-1:0] px);
        int unsigned gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= TDATA_W'(px);
        s_axis_tuser  <= mode;
        do @(posedge clk); while (!s_axis_tready);
        predict_erosion(mode, px);
        @(negedge clk);
    endtask

    // Stop sending, let every pending result drain, then a few extra
    // cycles since ignored items leave nothing in the queue to wait on.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (erosions_due.size() > 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Size registers are only touched between images with the block idle.
    task automatic set_size(input int unsigned w, input int unsigned h);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= REG_IMAGE_WIDTH;
        cfg_data  <= CFG_W'(w);
        @(posedge clk);
        width_reg = CFG_W'(w);
        @(negedge clk);
        cfg_index <= REG_IMAGE_HEIGHT;
        cfg_data  <= CFG_W'(h);
        @(posedge clk);
        height_reg = CFG_W'(h);
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Full image at the current size plus its drain ticks. With noise on,
    // stray drain ticks fall mid-image and stray pixels mid-drain; the
    // block drops both.
    task automatic send_image(input bit noisy);
        int unsigned w;
        int unsigned h;
        w = active_width();
        h = active_height();
        for (int unsigned i = 0; i < w * h; i++)
        begin
            if (noisy && $urandom_range(0, 15) == 0)
                send_item(MODE_DRAIN, PIXEL_BITS'($urandom));
            send_item(MODE_PIXEL, PIXEL_BITS'($urandom));
        end
        for (int unsigned i = 0; i < w; i++)
        begin
            if (noisy && $urandom_range(0, 15) == 0)
                send_item(MODE_PIXEL, PIXEL_BITS'($urandom));
            send_item(MODE_DRAIN, PIXEL_BITS'($urandom));
        end
        stream_items += w * h + w;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // 3x3 checkerboard of 0 / 15: corners and edges are border (zero), the
    // center sees only 15s. Also a drain tick before any pixel, a pixel
    // during the drain, and a single-row image that only drains.
    task automatic test_directed();
        logic [PIXEL_BITS-1:0] checker_px [9];
        checker_px = '{4'd0, 4'd15, 4'd0, 4'd15, 4'd0, 4'd15, 4'd0, 4'd15, 4'd0};
        set_size(3, 3);
        send_item(MODE_DRAIN, 4'd5);                  // not draining: dropped
        foreach (checker_px[i])
            send_item(MODE_PIXEL, checker_px[i]);
        send_item(MODE_PIXEL, 4'd7);                  // draining: dropped
        repeat (3) send_item(MODE_DRAIN, 4'd15);
        set_size(4, 1);
        send_item(MODE_PIXEL, 4'd15);
        send_item(MODE_PIXEL, 4'd0);
        send_item(MODE_PIXEL, 4'd9);
        send_item(MODE_PIXEL, 4'd6);
        repeat (4) send_item(MODE_DRAIN, 4'd0);
    endtask

    // Register extremes: 0 (acts as 1), the smallest sizes, and a tall
    // single column and a wide single row kept short.
    task automatic test_extreme_sizes();
        set_size(0, 0);
        send_image(1'b1);
        set_size(1, 1);
        send_image(1'b0);
        set_size(2, 2);
        send_image(1'b1);
        set_size(1, 40);
        send_image(1'b0);
        set_size(40, 1);
        send_image(1'b0);
    endtask

    // Mostly small random images back to back, sometimes resized, sometimes
    // paused until the output is empty, some with no idling at all.
    task automatic test_random_images();
        int unsigned w;
        int unsigned h;
        w = 5;
        h = 4;
        set_size(w, h);
        stream_items = 0;
        while (stream_items < RANDOM_ITEMS)
        begin
            burst = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 2) == 0)
            begin
                if ($urandom_range(0, 9) == 0)
                    w = $urandom_range(13, 64);
                else
                    w = $urandom_range(0, 12);
                h = $urandom_range(0, 8);
                set_size(w, h);
            end
            else if ($urandom_range(0, 3) == 0)
                settle();
            send_image(1'b1);
        end
        burst = 1'b0;
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = MODE_PIXEL;
        m_axis_tready = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_IMAGE_WIDTH;
        cfg_data      = '0;
        foreach (last_line[i])
        begin
            last_line[i]  = '0;
            older_line[i] = '0;
        end
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        test_extreme_sizes();
        test_random_images();

        // everything sent: wait for the last results, then a short tail
        settle();
        repeat (TAIL_CYCLES) @(negedge clk);

        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
